### sv/sound_voice_allocator_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sound voice allocator
// Shared property wrappers, clocked on the rising edge, held off in reset.
// ----------------------------------------------------------------------------
`ifndef SOUND_VOICE_ALLOCATOR_TOP_MACROS_SVH
`define SOUND_VOICE_ALLOCATOR_TOP_MACROS_SVH

// same-cycle implication
`define SVA_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SVA_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/svalloc_pkg.sv
// ----------------------------------------------------------------------------
// Sound voice allocator package
// Widths, reset values, microcode step/op/condition codes and the control ROM.
// ----------------------------------------------------------------------------
package svalloc_pkg;

    localparam int VOICES_DEFAULT   = 24;
    localparam int MAXV_W           = 5;
    localparam logic [MAXV_W-1:0] MAX_VOICE_RESET = 5'd24;
    localparam int COUNT_W          = 5;
    localparam int PRIO_W           = 8;
    localparam int KEY_W            = 16;
    localparam int AGE_W            = 8;
    localparam int MODE_W           = 2;
    localparam int MASK_W           = 24;

    localparam logic [MODE_W-1:0] MODE_FREE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd1;
    localparam logic [MODE_W-1:0] MODE_NOISE = 2'd2;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // microcode step addresses
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_IDLE     = 4'd0;
    localparam logic [STEP_W-1:0] STEP_DISP     = 4'd1;
    localparam logic [STEP_W-1:0] STEP_ROUND    = 4'd2;
    localparam logic [STEP_W-1:0] STEP_SCAN     = 4'd3;
    localparam logic [STEP_W-1:0] STEP_PICK     = 4'd4;
    localparam logic [STEP_W-1:0] STEP_LOOP     = 4'd5;
    localparam logic [STEP_W-1:0] STEP_UPD_INIT = 4'd6;
    localparam logic [STEP_W-1:0] STEP_UPDATE   = 4'd7;
    localparam logic [STEP_W-1:0] STEP_GRANT    = 4'd8;
    localparam logic [STEP_W-1:0] STEP_FAIL     = 4'd9;
    localparam logic [STEP_W-1:0] STEP_WRITE    = 4'd10;

    // datapath operations
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NONE       = 4'd0;
    localparam logic [OP_W-1:0] OP_ROUND_INIT = 4'd1;
    localparam logic [OP_W-1:0] OP_SCAN       = 4'd2;
    localparam logic [OP_W-1:0] OP_PICK       = 4'd3;
    localparam logic [OP_W-1:0] OP_UPD_INIT   = 4'd4;
    localparam logic [OP_W-1:0] OP_UPDATE     = 4'd5;
    localparam logic [OP_W-1:0] OP_DONE_OK    = 4'd6;
    localparam logic [OP_W-1:0] OP_DONE_FAIL  = 4'd7;
    localparam logic [OP_W-1:0] OP_WRITE      = 4'd8;

    // jump conditions
    localparam int COND_W = 3;
    localparam logic [COND_W-1:0] C_NEVER       = 3'd0;
    localparam logic [COND_W-1:0] C_ALWAYS      = 3'd1;
    localparam logic [COND_W-1:0] C_NO_START    = 3'd2;
    localparam logic [COND_W-1:0] C_CMD_WRITE   = 3'd3;
    localparam logic [COND_W-1:0] C_ROUNDS_DONE = 3'd4;
    localparam logic [COND_W-1:0] C_SCAN_CONT   = 3'd5;
    localparam logic [COND_W-1:0] C_NOT_FOUND   = 3'd6;
    localparam logic [COND_W-1:0] C_UPD_CONT    = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [COND_W-1:0] cond;
        logic [STEP_W-1:0] target;
    } t_uword;

    // control ROM: jump to target when cond holds, else fall through
    function automatic t_uword ucode(input logic [STEP_W-1:0] step);
        t_uword w;
        unique case (step)
            STEP_IDLE:     w = '{OP_NONE,       C_NO_START,    STEP_IDLE};
            STEP_DISP:     w = '{OP_NONE,       C_CMD_WRITE,   STEP_WRITE};
            STEP_ROUND:    w = '{OP_ROUND_INIT, C_ROUNDS_DONE, STEP_UPD_INIT};
            STEP_SCAN:     w = '{OP_SCAN,       C_SCAN_CONT,   STEP_SCAN};
            STEP_PICK:     w = '{OP_PICK,       C_NOT_FOUND,   STEP_FAIL};
            STEP_LOOP:     w = '{OP_NONE,       C_ALWAYS,      STEP_ROUND};
            STEP_UPD_INIT: w = '{OP_UPD_INIT,   C_NEVER,       STEP_IDLE};
            STEP_UPDATE:   w = '{OP_UPDATE,     C_UPD_CONT,    STEP_UPDATE};
            STEP_GRANT:    w = '{OP_DONE_OK,    C_ALWAYS,      STEP_IDLE};
            STEP_FAIL:     w = '{OP_DONE_FAIL,  C_ALWAYS,      STEP_IDLE};
            STEP_WRITE:    w = '{OP_WRITE,      C_ALWAYS,      STEP_IDLE};
            default:       w = '{OP_NONE,       C_ALWAYS,      STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

### sv/sound_voice_allocator_top.sv
// A voice write runs the DISP and WRITE steps; WRITE registers its result strobe.
// An allocation of N voices with scan limit L = min(max_voice, VOICES) runs up to
// N scan rounds and an update pass; the microcoded scan visits one voice per cycle.
// busy stays high for the whole request; one request at a time.
// Reset (synchronous, active low) clears all voice records and sets max_voice to 24.
// Results are one-cycle strobes; the receiver cannot stall them.
// ----------------------------------------------------------------------------
// Sound voice allocator, top level
// Microcoded sequencer over a per-voice register file: scan rounds pick
// voices to allocate or steal, then an update pass rewrites ages, priorities and modes.
// ----------------------------------------------------------------------------
`include "sound_voice_allocator_top_macros.svh"

module sound_voice_allocator_top #(
    parameter int VOICES = svalloc_pkg::VOICES_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_command,
    input  logic [svalloc_pkg::COUNT_W-1:0]   i_request_count,
    input  logic [svalloc_pkg::PRIO_W-1:0]    i_request_priority,
    input  logic [svalloc_pkg::MAXV_W-1:0]    i_voice_index,
    input  logic [svalloc_pkg::KEY_W-1:0]     i_key_status,
    input  logic [svalloc_pkg::MODE_W-1:0]    i_voice_mode,
    input  logic                              i_cfg_wr_en,
    input  logic [svalloc_pkg::MAXV_W-1:0]    i_cfg_wr_data,
    output logic                              o_result_valid,
    output logic                              o_granted,
    output logic [svalloc_pkg::MASK_W-1:0]    o_voice_mask,
    output logic [svalloc_pkg::MASK_W-1:0]    o_noise_off_mask
);

    localparam int VI_W  = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int CNT_W = $clog2(VOICES + 1);
    localparam logic [svalloc_pkg::MAXV_W-1:0] VOICES_V = svalloc_pkg::MAXV_W'(VOICES);

    // control state
    logic [svalloc_pkg::STEP_W-1:0]  r_pc, n_pc;
    logic                            r_result_valid;
    logic [svalloc_pkg::MAXV_W-1:0]  r_max_voice;

    // voice records
    logic [svalloc_pkg::PRIO_W-1:0]  r_voice_prio [VOICES];
    logic [svalloc_pkg::KEY_W-1:0]   r_voice_key  [VOICES];
    logic [svalloc_pkg::AGE_W-1:0]   r_voice_age  [VOICES];
    logic [svalloc_pkg::MODE_W-1:0]  r_voice_mode [VOICES];

    // latched request
    logic                            r_cmd;
    logic [svalloc_pkg::COUNT_W-1:0] r_count;
    logic [svalloc_pkg::PRIO_W-1:0]  r_prio;
    logic [svalloc_pkg::MAXV_W-1:0]  r_idx;
    logic [svalloc_pkg::KEY_W-1:0]   r_key;
    logic [svalloc_pkg::MODE_W-1:0]  r_mode;

    // scan datapath
    logic [CNT_W-1:0]                r_v;
    logic [svalloc_pkg::COUNT_W-1:0] r_rounds;
    logic [svalloc_pkg::COUNT_W-1:0] r_remaining;
    logic [svalloc_pkg::PRIO_W-1:0]  r_best_prio;
    logic [svalloc_pkg::KEY_W-1:0]   r_best_key;
    logic [svalloc_pkg::AGE_W-1:0]   r_best_age;
    logic                            r_steal_vld;
    logic [VI_W-1:0]                 r_steal_idx;
    logic                            r_free_vld;
    logic [VI_W-1:0]                 r_free_idx;
    logic [VOICES-1:0]               r_taken;
    logic [VOICES-1:0]               r_noise;
    logic                            r_granted;
    logic [svalloc_pkg::MASK_W-1:0]  r_voice_mask;
    logic [svalloc_pkg::MASK_W-1:0]  r_noise_mask;

    svalloc_pkg::t_uword uw;
    logic                            accept;
    logic [svalloc_pkg::MAXV_W-1:0]  lim;
    logic [VI_W-1:0]                 vi;
    logic                            v_in_range;
    logic                            v_eval;
    logic                            v_idle;
    logic [svalloc_pkg::PRIO_W-1:0]  cur_prio;
    logic [svalloc_pkg::KEY_W-1:0]   cur_key;
    logic [svalloc_pkg::AGE_W-1:0]   cur_age;
    logic [svalloc_pkg::MODE_W-1:0]  cur_mode;
    logic [svalloc_pkg::COUNT_W-1:0] rem_dec;
    logic                            cond_hit;
    logic                            idx_ok;

    // assertion helpers
    logic                            res_grant;
    logic                            cnt_ok;
    logic                            noise_ok;
    logic                            in_scan;
    logic                            scan_ok;

    assign uw     = svalloc_pkg::ucode(r_pc);
    assign busy   = (r_pc != svalloc_pkg::STEP_IDLE);
    assign accept = start && !busy;

    assign lim = (r_max_voice > VOICES_V) ? VOICES_V : r_max_voice;
    assign vi  = r_v[VI_W-1:0];
    assign v_in_range = (svalloc_pkg::MAXV_W'(r_v) < lim);

    assign cur_prio = r_voice_prio[vi];
    assign cur_key  = r_voice_key[vi];
    assign cur_age  = r_voice_age[vi];
    assign cur_mode = r_voice_mode[vi];

    assign v_eval  = v_in_range && !r_taken[vi];
    assign v_idle  = (cur_mode == svalloc_pkg::MODE_FREE) && (cur_key == '0);
    assign rem_dec = r_remaining - 1'b1;
    assign idx_ok  = (r_idx < VOICES_V);

    // sequencer branch
    always_comb begin
        unique case (uw.cond)
            svalloc_pkg::C_NEVER:       cond_hit = 1'b0;
            svalloc_pkg::C_ALWAYS:      cond_hit = 1'b1;
            svalloc_pkg::C_NO_START:    cond_hit = !start;
            svalloc_pkg::C_CMD_WRITE:   cond_hit = (r_cmd == svalloc_pkg::CMD_WRITE);
            svalloc_pkg::C_ROUNDS_DONE: cond_hit = (r_rounds == '0);
            svalloc_pkg::C_SCAN_CONT:   cond_hit = v_in_range && !(v_eval && v_idle);
            svalloc_pkg::C_NOT_FOUND:   cond_hit = !r_steal_vld && !r_free_vld;
            svalloc_pkg::C_UPD_CONT:    cond_hit = v_in_range;
            default:                    cond_hit = 1'b0;
        endcase
        n_pc = cond_hit ? uw.target : r_pc + 1'b1;
    end

    // control state and voice records
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc           <= svalloc_pkg::STEP_IDLE;
            r_result_valid <= 1'b0;
            r_max_voice    <= svalloc_pkg::MAX_VOICE_RESET;
            for (int i = 0; i < VOICES; i++) begin
                r_voice_prio[i] <= '0;
                r_voice_key[i]  <= '0;
                r_voice_age[i]  <= '0;
                r_voice_mode[i] <= '0;
            end
        end else begin
            r_pc           <= n_pc;
            r_result_valid <= (uw.op == svalloc_pkg::OP_DONE_OK) ||
                              (uw.op == svalloc_pkg::OP_DONE_FAIL) ||
                              (uw.op == svalloc_pkg::OP_WRITE);
            if (i_cfg_wr_en) begin
                r_max_voice <= i_cfg_wr_data;
            end
            if (uw.op == svalloc_pkg::OP_UPDATE && v_in_range) begin
                if (r_taken[vi]) begin
                    r_voice_age[vi]  <= svalloc_pkg::AGE_W'(rem_dec);
                    r_voice_prio[vi] <= r_prio;
                    r_voice_mode[vi] <= svalloc_pkg::MODE_ALLOC;
                end else begin
                    r_voice_age[vi]  <= cur_age + svalloc_pkg::AGE_W'(r_count);
                end
            end
            if (uw.op == svalloc_pkg::OP_WRITE && idx_ok) begin
                r_voice_key[r_idx[VI_W-1:0]]  <= r_key;
                r_voice_mode[r_idx[VI_W-1:0]] <= r_mode;
            end
        end
    end

    // request latch and scan datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd   <= i_command;
            r_count <= i_request_count;
            r_prio  <= i_request_priority;
            r_idx   <= i_voice_index;
            r_key   <= i_key_status;
            r_mode  <= i_voice_mode;
            r_rounds <= i_request_count;
            r_taken <= '0;
        end
        case (uw.op) inside
            svalloc_pkg::OP_ROUND_INIT: begin
                r_v         <= '0;
                r_best_prio <= r_prio;
                r_best_key  <= '1;
                r_best_age  <= '0;
                r_steal_vld <= 1'b0;
                r_free_vld  <= 1'b0;
            end
            svalloc_pkg::OP_SCAN: begin
                if (v_in_range) begin
                    r_v <= r_v + 1'b1;
                end
                if (v_eval) begin
                    if (v_idle) begin
                        r_free_vld <= 1'b1;
                        r_free_idx <= vi;
                    end else if (cur_prio < r_best_prio) begin
                        r_best_prio <= cur_prio;
                        r_best_key  <= cur_key;
                        r_best_age  <= cur_age;
                        r_steal_vld <= 1'b1;
                        r_steal_idx <= vi;
                    end else if (cur_prio == r_best_prio) begin
                        if (cur_key < r_best_key) begin
                            r_best_key  <= cur_key;
                            r_best_age  <= cur_age;
                            r_steal_vld <= 1'b1;
                            r_steal_idx <= vi;
                        end else if (cur_key == r_best_key && cur_age > r_best_age) begin
                            r_best_age  <= cur_age;
                            r_steal_vld <= 1'b1;
                            r_steal_idx <= vi;
                        end
                    end
                end
            end
            svalloc_pkg::OP_PICK: begin
                // a steal candidate wins over the free voice
                if (r_steal_vld) begin
                    r_taken[r_steal_idx] <= 1'b1;
                end else if (r_free_vld) begin
                    r_taken[r_free_idx] <= 1'b1;
                end
                r_rounds <= r_rounds - 1'b1;
            end
            svalloc_pkg::OP_UPD_INIT: begin
                r_v         <= '0;
                r_remaining <= r_count;
                r_noise     <= '0;
            end
            svalloc_pkg::OP_UPDATE: begin
                if (v_in_range) begin
                    r_v <= r_v + 1'b1;
                    if (r_taken[vi]) begin
                        r_remaining <= rem_dec;
                        r_noise[vi] <= (cur_mode == svalloc_pkg::MODE_NOISE);
                    end
                end
            end
            svalloc_pkg::OP_DONE_OK: begin
                r_granted    <= 1'b1;
                r_voice_mask <= svalloc_pkg::MASK_W'(r_taken);
                r_noise_mask <= svalloc_pkg::MASK_W'(r_noise);
            end
            svalloc_pkg::OP_DONE_FAIL, svalloc_pkg::OP_WRITE: begin
                r_granted    <= 1'b0;
                r_voice_mask <= '0;
                r_noise_mask <= '0;
            end
            default: begin
            end
        endcase
    end

    assign o_result_valid   = r_result_valid;
    assign o_granted        = r_granted;
    assign o_voice_mask     = r_voice_mask;
    assign o_noise_off_mask = r_noise_mask;

    assign res_grant = o_result_valid && o_granted;
    assign cnt_ok    = ($countones(r_taken) == int'(r_count));
    assign noise_ok  = ((o_noise_off_mask & ~o_voice_mask) == '0);
    assign in_scan   = (r_pc == svalloc_pkg::STEP_SCAN) || (r_pc == svalloc_pkg::STEP_UPDATE);
    assign scan_ok   = (svalloc_pkg::MAXV_W'(r_v) <= lim);

    `SVA_NEXT(a_accept_busy, i_clk, i_rst_n, accept, busy, "request taken but not busy")
    `SVA_IMPLIES(a_grant_count, i_clk, i_rst_n, res_grant, cnt_ok, "grant count off")
    `SVA_IMPLIES(a_noise_subset, i_clk, i_rst_n, o_result_valid, noise_ok, "stray noise-off bit")
    `SVA_IMPLIES(a_scan_bound, i_clk, i_rst_n, in_scan, scan_ok, "scan past limit")

endmodule

### tb/sv/sound_voice_allocator_top_tb.sv
// ----------------------------------------------------------------------------
// Sound voice allocator testbench
// Drives allocate and voice-write requests through the start/busy handshake,
// predicts every grant from its own copy of the voice records, and checks
// each result strobe field by field. A short directed list covers the edge
// cases; a long random run follows across several max_voice settings.
// ----------------------------------------------------------------------------
module sound_voice_allocator_top_tb;
    import svalloc_pkg::*;

    localparam int NV          = VOICES_DEFAULT;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int PHASES      = 9;
    localparam logic [MODE_W-1:0] MODE_HOLD = 2'd3;  // undefined mode, never idle

    typedef struct packed {
        logic               cmd;
        logic [COUNT_W-1:0] count;
        logic [PRIO_W-1:0]  prio;
        logic [MAXV_W-1:0]  idx;
        logic [KEY_W-1:0]   key;
        logic [MODE_W-1:0]  mode;
    } voice_req_t;

    typedef struct packed {
        logic              granted;
        logic [MASK_W-1:0] vmask;
        logic [MASK_W-1:0] nmask;
    } grant_t;

    typedef struct {
        int         cfg;     // max_voice to set first, -1 keeps it
        voice_req_t rq;
        bit         typed;
        grant_t     want;
    } dir_row_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               i_command = 1'b0;
    logic [COUNT_W-1:0] i_request_count = '0;
    logic [PRIO_W-1:0]  i_request_priority = '0;
    logic [MAXV_W-1:0]  i_voice_index = '0;
    logic [KEY_W-1:0]   i_key_status = '0;
    logic [MODE_W-1:0]  i_voice_mode = '0;
    logic               i_cfg_wr_en = 1'b0;
    logic [MAXV_W-1:0]  i_cfg_wr_data = '0;
    logic               o_result_valid;
    logic               o_granted;
    logic [MASK_W-1:0]  o_voice_mask;
    logic [MASK_W-1:0]  o_noise_off_mask;

    always #6 i_clk = ~i_clk;

    sound_voice_allocator_top #(.VOICES(NV)) uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_command          (i_command),
        .i_request_count    (i_request_count),
        .i_request_priority (i_request_priority),
        .i_voice_index      (i_voice_index),
        .i_key_status       (i_key_status),
        .i_voice_mode       (i_voice_mode),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_wr_data      (i_cfg_wr_data),
        .o_result_valid     (o_result_valid),
        .o_granted          (o_granted),
        .o_voice_mask       (o_voice_mask),
        .o_noise_off_mask   (o_noise_off_mask)
    );

    // shadow voice records
    logic [PRIO_W-1:0] v_prio [NV];
    logic [KEY_W-1:0]  v_key  [NV];
    logic [AGE_W-1:0]  v_age  [NV];
    logic [MODE_W-1:0] v_mode [NV];
    logic [MAXV_W-1:0] max_voice_cfg = MAX_VOICE_RESET;

    grant_t   grant_queue[$];
    dir_row_t dir_rows[$];
    int       err_count = 0;
    int       cycle_count = 0;

    function automatic int scan_len();
        return (max_voice_cfg > NV) ? NV : int'(max_voice_cfg);
    endfunction

    // one scan round; -1 when nothing can be taken
    function automatic int find_voice(logic [NV-1:0] taken, logic [PRIO_W-1:0] prio);
        int               lim;
        int               steal;
        int               free_v;
        logic [PRIO_W-1:0] bp;
        logic [KEY_W-1:0]  bk;
        logic [AGE_W-1:0]  ba;
        lim    = scan_len();
        steal  = -1;
        free_v = -1;
        bp     = prio;
        bk     = '1;
        ba     = '0;
        for (int v = 0; v < lim; v++) begin
            if (taken[v])
                continue;
            if (v_mode[v] == MODE_FREE && v_key[v] == '0) begin
                free_v = v;
                break;
            end
            if (v_prio[v] < bp) begin
                bp = v_prio[v];
                bk = v_key[v];
                ba = v_age[v];
                steal = v;
            end else if (v_prio[v] == bp) begin
                if (v_key[v] < bk) begin
                    bk = v_key[v];
                    ba = v_age[v];
                    steal = v;
                end else if (v_key[v] == bk && v_age[v] > ba) begin
                    ba = v_age[v];
                    steal = v;
                end
            end
        end
        return (steal >= 0) ? steal : free_v;
    endfunction

    function automatic grant_t predict_grant(voice_req_t rq);
        grant_t        res;
        logic [NV-1:0] taken;
        int            pick;
        int            lim;
        int            left;
        res   = '0;
        taken = '0;
        if (rq.cmd == CMD_WRITE) begin
            if (rq.idx < NV) begin
                v_key[rq.idx]  = rq.key;
                v_mode[rq.idx] = rq.mode;
            end
            return res;
        end
        for (int r = 0; r < rq.count; r++) begin
            pick = find_voice(taken, rq.prio);
            if (pick < 0)
                return res;
            taken[pick] = 1'b1;
        end
        lim  = scan_len();
        left = rq.count;
        for (int v = 0; v < lim; v++) begin
            if (taken[v]) begin
                left--;
                v_age[v]  = AGE_W'(left);
                v_prio[v] = rq.prio;
                if (v_mode[v] == MODE_NOISE)
                    res.nmask[v] = 1'b1;
                v_mode[v] = MODE_ALLOC;
            end else begin
                v_age[v] = v_age[v] + AGE_W'(rq.count);
            end
        end
        res.granted = 1'b1;
        res.vmask   = MASK_W'(taken);
        return res;
    endfunction

    function automatic voice_req_t gen_request();
        voice_req_t rq;
        int         r;
        rq.cmd   = CMD_ALLOC;
        rq.count = COUNT_W'($urandom);
        rq.prio  = PRIO_W'($urandom);
        rq.idx   = MAXV_W'($urandom);
        rq.key   = KEY_W'($urandom);
        rq.mode  = MODE_W'($urandom);
        if ($urandom_range(0, 99) < 45) begin
            rq.cmd = CMD_WRITE;
            rq.idx = ($urandom_range(0, 19) == 0) ? MAXV_W'($urandom_range(24, 31))
                                                  : MAXV_W'($urandom_range(0, 23));
            r = $urandom_range(0, 9);
            if (r < 5)
                rq.key = '0;                       // key released
            else if (r < 7)
                rq.key = KEY_W'($urandom_range(1, 15));
            else if (r == 7)
                rq.key = '1;
            r = $urandom_range(0, 19);
            if (r < 8)
                rq.mode = MODE_FREE;
            else if (r < 14)
                rq.mode = MODE_ALLOC;
            else if (r < 19)
                rq.mode = MODE_NOISE;
            else
                rq.mode = MODE_HOLD;
        end else begin
            r = $urandom_range(0, 19);
            if (r == 0)
                rq.count = '0;
            else if (r < 16)
                rq.count = COUNT_W'($urandom_range(1, 4));
            else if (r < 19)
                rq.count = COUNT_W'($urandom_range(5, 12));
            else
                rq.count = COUNT_W'($urandom_range(13, 24));
            r = $urandom_range(0, 7);
            if (r == 0)
                rq.prio = '0;
            else if (r == 1)
                rq.prio = '1;
            else if (r < 4)
                rq.prio = $urandom_range(0, 1) ? 8'h40 : 8'h80;
        end
        return rq;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic add_row(input int cfg, input logic cmd, input int count, input int prio,
                           input int idx, input int key, input int mode,
                           input int want_g, input int want_vm, input int want_nm);
        dir_row_t row;
        row.cfg      = cfg;
        row.rq.cmd   = cmd;
        row.rq.count = COUNT_W'(count);
        row.rq.prio  = PRIO_W'(prio);
        row.rq.idx   = MAXV_W'(idx);
        row.rq.key   = KEY_W'(key);
        row.rq.mode  = MODE_W'(mode);
        row.typed    = (want_g >= 0);
        row.want     = {1'(want_g), MASK_W'(want_vm), MASK_W'(want_nm)};
        dir_rows.push_back(row);
    endtask

    task automatic issue(input voice_req_t rq, input bit typed, input grant_t want);
        grant_t pred;
        i_command          <= rq.cmd;
        i_request_count    <= rq.count;
        i_request_priority <= rq.prio;
        i_voice_index      <= rq.idx;
        i_key_status       <= rq.key;
        i_voice_mode       <= rq.mode;
        start              <= 1'b1;
        do @(posedge i_clk); while (busy);
        pred = predict_grant(rq);
        grant_queue.push_back(typed ? want : pred);
    endtask

    task automatic pause(input int n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic drain_idle();
        start <= 1'b0;
        do @(posedge i_clk); while (grant_queue.size() != 0 || busy);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_max_voice(input int v);
        drain_idle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= MAXV_W'(v);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        max_voice_cfg = MAXV_W'(v);
    endtask

    always @(posedge i_clk) begin
        grant_t got;
        grant_t want;
        if (i_rst_n && o_result_valid) begin
            got = {o_granted, o_voice_mask, o_noise_off_mask};
            if (grant_queue.size() == 0) begin
                $display("%0t: result with no request pending: expected none, actual %h",
                         $time, got);
                err_count++;
            end else begin
                want = grant_queue.pop_front();
                if (got.granted !== want.granted) begin
                    $display("%0t: granted expected %0b actual %0b",
                             $time, want.granted, got.granted);
                    err_count++;
                end
                if (got.vmask !== want.vmask) begin
                    $display("%0t: voice_mask expected %h actual %h",
                             $time, want.vmask, got.vmask);
                    err_count++;
                end
                if (got.nmask !== want.nmask) begin
                    $display("%0t: noise_off_mask expected %h actual %h",
                             $time, want.nmask, got.nmask);
                    err_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("sound_voice_allocator_top_tb: done, errors");
            $finish;
        end
    end

    initial begin
        int phase_cfg [PHASES];
        int phase_len [PHASES];
        int gap;
        for (int v = 0; v < NV; v++) begin
            v_prio[v] = '0;
            v_key[v]  = '0;
            v_age[v]  = '0;
            v_mode[v] = MODE_FREE;
        end
        phase_cfg = '{24, 31, 8, 1, 0, 24, 0, 0, 24};
        phase_cfg[6] = $urandom_range(2, 23);
        phase_cfg[7] = $urandom_range(25, 30);   // saturates at the voice count
        phase_len = '{110, 100, 110, 80, 20, 110, 110, 100, 110};

        // zero count grants with empty masks; all idle picks voice 0 first
        add_row(-1, CMD_ALLOC,  0,   0,  0, 0,       0,          1, 0, 0);
        add_row(-1, CMD_ALLOC,  1,   0,  0, 0,       0,          1, 1, 0);
        add_row(-1, CMD_ALLOC, 24, 255,  0, 0,       0,          1, 'hFFFFFF, 0);
        add_row(-1, CMD_WRITE,  0,   0,  5, 0,       MODE_NOISE, 0, 0, 0);
        add_row(-1, CMD_WRITE,  0,   0, 23, 'hFFFF,  MODE_HOLD,  0, 0, 0);
        // out-of-range voice index is dropped
        add_row(-1, CMD_WRITE, 31, 255, 24, 'h1234,  MODE_ALLOC, 0, 0, 0);
        add_row(-1, CMD_WRITE,  0,   0, 31, 'hFFFF,  MODE_HOLD,  0, 0, 0);
        add_row(-1, CMD_WRITE,  0,   0,  6, 0,       MODE_NOISE, 0, 0, 0);
        add_row(-1, CMD_ALLOC,  3, 255,  0, 0,       0,         -1, 0, 0);
        add_row(-1, CMD_ALLOC,  2, 'h80, 0, 0,       0,         -1, 0, 0);
        add_row(-1, CMD_ALLOC, 24,   0,  0, 0,       0,         -1, 0, 0);
        // nothing scanned: any nonzero count fails
        add_row( 0, CMD_ALLOC,  1, 255,  0, 0,       0,          0, 0, 0);
        add_row(-1, CMD_ALLOC,  0,   9,  0, 0,       0,          1, 0, 0);
        add_row(31, CMD_ALLOC,  5, 200,  0, 0,       0,         -1, 0, 0);
        add_row(-1, CMD_ALLOC, 24, 255,  0, 0,       0,         -1, 0, 0);
        add_row( 4, CMD_ALLOC,  5, 255,  0, 0,       0,          0, 0, 0);
        // single voice: key 0xffff, age 0 at the request priority is never stolen
        add_row( 1, CMD_WRITE,  0,   0,  0, 0,       MODE_FREE,  0, 0, 0);
        add_row(-1, CMD_ALLOC,  1, 'h40, 0, 0,       0,          1, 1, 0);
        add_row(-1, CMD_WRITE,  0,   0,  0, 'hFFFF,  MODE_ALLOC, 0, 0, 0);
        add_row(-1, CMD_ALLOC,  1, 'h40, 0, 0,       0,          0, 0, 0);
        add_row(-1, CMD_ALLOC,  1, 'h41, 0, 0,       0,          1, 1, 0);
        add_row(24, CMD_WRITE,  0,   0, 10, 'h8000,  MODE_NOISE, 0, 0, 0);
        add_row(-1, CMD_ALLOC, 24, 255,  0, 0,       0,         -1, 0, 0);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].cfg >= 0)
                set_max_voice(dir_rows[i].cfg);
            issue(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].want);
            pause(pick_gap());
        end

        for (int p = 0; p < PHASES; p++) begin
            set_max_voice(phase_cfg[p]);
            for (int n = 0; n < phase_len[p]; n++) begin
                issue(gen_request(), 1'b0, '0);
                // hold off until every pending request has answered
                if ((p == 0 && n == 50) || $urandom_range(0, 149) == 0)
                    drain_idle();
                gap = ((n % 40) < 12) ? 0 : pick_gap();
                pause(gap);
            end
        end

        drain_idle();
        repeat (64) @(posedge i_clk);
        if (err_count == 0)
            $display("sound_voice_allocator_top_tb: done, clean");
        else
            $display("sound_voice_allocator_top_tb: done, errors");
        $finish;
    end

endmodule

### sim.f
+incdir+sv
sv/svalloc_pkg.sv
sv/sound_voice_allocator_top.sv
tb/sv/sound_voice_allocator_top_tb.sv
